FILE: sv/ptpm_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the priority table: item kinds, status codes, field widths.
package ptpm_pkg;

    // Default sizing of the table
    localparam int DEF_TABLE_DEPTH    = 256;
    localparam int DEF_PAYLOAD_WIDTH  = 32;
    localparam int DEF_PRIORITY_WIDTH = 16;

    // Field widths on the ports
    localparam int KIND_W       = 3;
    localparam int STATUS_W     = 2;
    localparam int ID_FIELD_W   = 8;
    localparam int PAY_FIELD_W  = 32;
    localparam int PRIO_FIELD_W = 16;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 64;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_ADD     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PROMOTE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PEEK    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ    = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BADID = 2'd3;

endpackage

FILE: sv/ptpm_ram.sv
`timescale 1ns / 1ps
// Entry memory: one write port, one read port, registered read data.
module ptpm_ram #(
    parameter int DEPTH = ptpm_pkg::DEF_TABLE_DEPTH,
    parameter int WIDTH = 1 + ptpm_pkg::DEF_PRIORITY_WIDTH + ptpm_pkg::DEF_PAYLOAD_WIDTH
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/ptpm_maxscan.sv
`timescale 1ns / 1ps
// Running maximum over entries streamed out of the memory; later index wins ties.
module ptpm_maxscan #(
    parameter int ID_W   = 8,
    parameter int PRIO_W = ptpm_pkg::DEF_PRIORITY_WIDTH,
    parameter int PAY_W  = ptpm_pkg::DEF_PAYLOAD_WIDTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clear,
    input  logic              in_vld,
    input  logic [ID_W-1:0]   in_idx,
    input  logic              in_entry_valid,
    input  logic [PRIO_W-1:0] in_prio,
    input  logic [PAY_W-1:0]  in_payload,
    output logic              found,
    output logic [ID_W-1:0]   best_idx,
    output logic [PRIO_W-1:0] best_prio,
    output logic [PAY_W-1:0]  best_payload
);

    logic              found_reg;
    logic [ID_W-1:0]   best_idx_reg;
    logic [PRIO_W-1:0] best_prio_reg;
    logic [PAY_W-1:0]  best_payload_reg;
    logic              take;

    // >= so that a later (larger) id replaces an equal priority
    assign take = in_vld && in_entry_valid && (!found_reg || (in_prio >= best_prio_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (clear) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            best_idx_reg     <= in_idx;
            best_prio_reg    <= in_prio;
            best_payload_reg <= in_payload;
        end
    end

    assign found        = found_reg;
    assign best_idx     = best_idx_reg;
    assign best_prio    = best_prio_reg;
    assign best_payload = best_payload_reg;

endmodule

FILE: sv/priority_table_promote_pop_max_top.sv
`timescale 1ns / 1ps
// Top level of the priority table with add, promote, pop-max, peek-max and read.
//
// One item is worked on at a time; the next item is taken as soon as the previous
// result sits in the output register, even if the sink has not yet taken it.
// Add, unused kinds, a pop or peek before any add and an out-of-range id are
// answered without a memory read; promote and read make one read of the entry
// memory, then a write back for promote; pop and peek, once ids have been
// issued, walk the issued entries through the single read port of the entry
// memory, one entry per cycle, for the max search.
// Each entry holds {payload, priority, valid} in one synchronous RAM. Ids are
// never reused, so entries at or above the issued-id count were never written
// and count as empty: there is no clearing pass after reset.
module priority_table_promote_pop_max_top #(
    parameter int TABLE_DEPTH    = ptpm_pkg::DEF_TABLE_DEPTH,
    parameter int PAYLOAD_WIDTH  = ptpm_pkg::DEF_PAYLOAD_WIDTH,
    parameter int PRIORITY_WIDTH = ptpm_pkg::DEF_PRIORITY_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input item channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ptpm_pkg::S_TDATA_W-1:0]  s_tdata,   // entry_id[7:0], payload_in[39:8]
    input  logic [ptpm_pkg::KIND_W-1:0]     s_tuser,   // kind[2:0]
    // result item channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ptpm_pkg::M_TDATA_W-1:0]  m_tdata,   // result_id[7:0], payload_out[39:8],
                                                       // priority_out[55:40], entry_valid[56]
    output logic [ptpm_pkg::STATUS_W-1:0]   m_tuser    // status[1:0]
);

    localparam int ID_W    = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int PAY_W   = PAYLOAD_WIDTH;
    localparam int PRIO_W  = PRIORITY_WIDTH;
    localparam int WORD_W  = 1 + PRIO_W + PAY_W;
    localparam int IDF_W   = ptpm_pkg::ID_FIELD_W;
    localparam int PF_W    = ptpm_pkg::PAY_FIELD_W;
    localparam int PRF_W   = ptpm_pkg::PRIO_FIELD_W;
    localparam int ST_W    = ptpm_pkg::STATUS_W;
    localparam int K_W     = ptpm_pkg::KIND_W;
    localparam int CMP_W   = (CNT_W > IDF_W) ? CNT_W : IDF_W;
    localparam int M_PAD_W = ptpm_pkg::M_TDATA_W - (IDF_W + PF_W + PRF_W + 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MOD   = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;
    localparam logic [2:0] ST_HOLD  = 3'd5;

    // input fields
    logic [K_W-1:0]   in_kind;
    logic [IDF_W-1:0] in_id;
    logic [PF_W-1:0]  in_payload;

    assign in_kind    = s_tuser;
    assign in_id      = s_tdata[IDF_W-1:0];
    assign in_payload = s_tdata[IDF_W+PF_W-1:IDF_W];

    // control state
    logic [2:0]       state_reg, state_next;
    logic [K_W-1:0]   kind_reg, kind_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;         // ids issued so far
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic             scan_vld_reg, scan_vld_next;
    logic [ID_W-1:0]  scan_idx_reg, scan_idx_next;

    // result waiting for the output register
    logic [ST_W-1:0]  pend_status_reg, pend_status_next;
    logic [IDF_W-1:0] pend_id_reg, pend_id_next;
    logic [PF_W-1:0]  pend_payload_reg, pend_payload_next;
    logic [PRF_W-1:0] pend_prio_reg, pend_prio_next;
    logic             pend_evalid_reg, pend_evalid_next;

    // output register
    logic             m_valid_reg;
    logic [ST_W-1:0]  m_status_reg;
    logic [IDF_W-1:0] m_id_reg;
    logic [PF_W-1:0]  m_payload_reg;
    logic [PRF_W-1:0] m_prio_reg;
    logic             m_evalid_reg;
    logic             out_load;

    // memory ports
    logic              wr_en;
    logic [ID_W-1:0]   wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [ID_W-1:0]   rd_addr;
    logic [WORD_W-1:0] rd_data;

    // fields of the word read back
    logic              rd_valid;
    logic [PRIO_W-1:0] rd_prio;
    logic [PAY_W-1:0]  rd_payload;
    logic [PRIO_W-1:0] prio_inc;

    // max search
    logic              best_found;
    logic [ID_W-1:0]   best_idx;
    logic [PRIO_W-1:0] best_prio;
    logic [PAY_W-1:0]  best_payload;

    logic             accept;
    logic [CMP_W-1:0] id_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             cnt_full;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign id_ext   = CMP_W'(in_id);
    assign cnt_ext  = CMP_W'(cnt_reg);
    assign cnt_full = (cnt_reg == CNT_W'(TABLE_DEPTH));

    assign rd_valid   = rd_data[0];
    assign rd_prio    = rd_data[PRIO_W:1];
    assign rd_payload = rd_data[WORD_W-1:PRIO_W+1];
    // saturating increment
    assign prio_inc   = (rd_prio == {PRIO_W{1'b1}}) ? rd_prio : rd_prio + PRIO_W'(1);

    // output register frees when empty or when its item is taken
    assign out_load = (state_reg == ST_HOLD) && (!m_valid_reg || m_tready);

    ptpm_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (WORD_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ptpm_maxscan #(
        .ID_W   (ID_W),
        .PRIO_W (PRIO_W),
        .PAY_W  (PAY_W)
    ) u_maxscan (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .clear          (accept),
        .in_vld         (scan_vld_reg),
        .in_idx         (scan_idx_reg),
        .in_entry_valid (rd_valid),
        .in_prio        (rd_prio),
        .in_payload     (rd_payload),
        .found          (best_found),
        .best_idx       (best_idx),
        .best_prio      (best_prio),
        .best_payload   (best_payload)
    );

    always_comb begin
        state_next        = state_reg;
        kind_next         = kind_reg;
        id_next           = id_reg;
        cnt_next          = cnt_reg;
        scan_cnt_next     = scan_cnt_reg;
        scan_vld_next     = 1'b0;
        scan_idx_next     = scan_idx_reg;
        pend_status_next  = pend_status_reg;
        pend_id_next      = pend_id_reg;
        pend_payload_next = pend_payload_reg;
        pend_prio_next    = pend_prio_reg;
        pend_evalid_next  = pend_evalid_reg;
        wr_en             = 1'b0;
        wr_addr           = '0;
        wr_data           = '0;
        rd_en             = 1'b0;
        rd_addr           = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    kind_next         = in_kind;
                    id_next           = ID_W'(id_ext);
                    pend_status_next  = ptpm_pkg::STAT_OK;
                    pend_id_next      = '0;
                    pend_payload_next = '0;
                    pend_prio_next    = '0;
                    pend_evalid_next  = 1'b0;
                    state_next        = ST_HOLD;
                    unique case (in_kind)
                        ptpm_pkg::KIND_ADD: begin
                            if (cnt_full) begin
                                pend_status_next = ptpm_pkg::STAT_FULL;
                            end else begin
                                wr_en        = 1'b1;
                                wr_addr      = cnt_reg[ID_W-1:0];
                                wr_data      = {PAY_W'(in_payload), {PRIO_W{1'b0}}, 1'b1};
                                cnt_next     = cnt_reg + CNT_W'(1);
                                pend_id_next = IDF_W'(cnt_reg);
                            end
                        end
                        ptpm_pkg::KIND_PROMOTE, ptpm_pkg::KIND_READ: begin
                            // ids at or above the issued count were never written
                            if (id_ext >= cnt_ext) begin
                                pend_status_next = ptpm_pkg::STAT_BADID;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = ID_W'(id_ext);
                                state_next = ST_MOD;
                            end
                        end
                        ptpm_pkg::KIND_POP, ptpm_pkg::KIND_PEEK: begin
                            if (cnt_reg == '0) begin
                                pend_status_next = ptpm_pkg::STAT_EMPTY;
                            end else begin
                                scan_cnt_next = '0;
                                state_next    = ST_SCAN;
                            end
                        end
                        default: begin
                            // unused kind: all-zero result
                        end
                    endcase
                end
            end
            ST_MOD: begin
                state_next = ST_HOLD;
                if (!rd_valid) begin
                    pend_status_next = ptpm_pkg::STAT_BADID;
                end else if (kind_reg == ptpm_pkg::KIND_PROMOTE) begin
                    wr_en          = 1'b1;
                    wr_addr        = id_reg;
                    wr_data        = {rd_payload, prio_inc, 1'b1};
                    pend_id_next   = IDF_W'(id_reg);
                    pend_prio_next = PRF_W'(prio_inc);
                end else begin
                    pend_id_next      = IDF_W'(id_reg);
                    pend_payload_next = PF_W'(rd_payload);
                    pend_prio_next    = PRF_W'(rd_prio);
                    pend_evalid_next  = 1'b1;
                end
            end
            ST_SCAN: begin
                // one entry per cycle; its data meets the max unit in the next cycle
                rd_en         = 1'b1;
                rd_addr       = scan_cnt_reg[ID_W-1:0];
                scan_vld_next = 1'b1;
                scan_idx_next = scan_cnt_reg[ID_W-1:0];
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                if (scan_cnt_reg + CNT_W'(1) == cnt_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                state_next = ST_HOLD;
                if (!best_found) begin
                    pend_status_next = ptpm_pkg::STAT_EMPTY;
                end else begin
                    pend_id_next      = IDF_W'(best_idx);
                    pend_payload_next = PF_W'(best_payload);
                    pend_prio_next    = PRF_W'(best_prio);
                    if (kind_reg == ptpm_pkg::KIND_POP) begin
                        // removal clears valid and priority
                        wr_en   = 1'b1;
                        wr_addr = best_idx;
                        wr_data = {best_payload, {PRIO_W{1'b0}}, 1'b0};
                    end
                end
            end
            ST_HOLD: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            scan_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            scan_vld_reg <= scan_vld_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg         <= kind_next;
        id_reg           <= id_next;
        scan_cnt_reg     <= scan_cnt_next;
        scan_idx_reg     <= scan_idx_next;
        pend_status_reg  <= pend_status_next;
        pend_id_reg      <= pend_id_next;
        pend_payload_reg <= pend_payload_next;
        pend_prio_reg    <= pend_prio_next;
        pend_evalid_reg  <= pend_evalid_next;
        if (out_load) begin
            m_status_reg  <= pend_status_reg;
            m_id_reg      <= pend_id_reg;
            m_payload_reg <= pend_payload_reg;
            m_prio_reg    <= pend_prio_reg;
            m_evalid_reg  <= pend_evalid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_evalid_reg, m_prio_reg, m_payload_reg, m_id_reg};

endmodule
